// ===== hdl/cfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcd_pkg: shared types and decode tables of the command frame checker
// payload structs, status codes, crc-8 step and the event code decoder
// ----------------------------------------------------------------------------
package cfcd_pkg;

  // input transfer payload
  typedef struct packed {
    logic [7:0]  pkt_byte;
    logic        pkt_last;
    logic [31:0] now_ms;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  event_code;
    logic [31:0] frame_word;
    logic [7:0]  seq_num;
  } out_t;

  // what the packet collector knows when the last byte arrives
  typedef struct packed {
    logic        len_ok;
    logic        crc_ok;
    logic [31:0] frame;
    logic [7:0]  seq;
  } pkt_info_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_CRC_ERR   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_SYSTEM    = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  localparam logic [7:0]  CRC_POLY      = 8'h07;
  localparam logic [2:0]  CNT_LAST_IDX  = 3'd5;
  localparam logic [2:0]  CNT_MAX       = 3'd7;
  localparam logic [15:0] WINDOW_RESET  = 16'd500;
  localparam logic [7:0]  SEQ_RESET     = 8'hFF;

  // frame classes
  localparam logic [7:0] CLS_CLOCK    = 8'h01;
  localparam logic [7:0] CLS_SCORE    = 8'h02;
  localparam logic [7:0] CLS_CARD     = 8'h03;
  localparam logic [7:0] CLS_MATCH    = 8'h04;
  localparam logic [7:0] CLS_COMP     = 8'h06;
  localparam logic [7:0] CLS_SYSTEM   = 8'h07;
  localparam logic [7:0] CLS_SETTINGS = 8'h08;

  localparam logic [7:0] SIDE_LEFT  = 8'h01;
  localparam logic [7:0] SIDE_RIGHT = 8'h02;

  // commands
  localparam logic [5:0] CMD_BASE        = 6'd0;
  localparam logic [5:0] CMD_YELLOW      = 6'd0;
  localparam logic [5:0] CMD_RED         = 6'd1;
  localparam logic [5:0] CMD_BLACK       = 6'd2;
  localparam logic [5:0] CMD_PCARD       = 6'd4;
  localparam logic [5:0] CMD_BLACK_P     = 6'd5;
  localparam logic [5:0] CMD_UNWILLING   = 6'd6;
  localparam logic [5:0] CMD_NEXT_PERIOD = 6'd0;
  localparam logic [5:0] CMD_MATCH_RESET = 6'd1;
  localparam logic [5:0] CMD_PRIO_A      = 6'd2;
  localparam logic [5:0] CMD_PRIO_B      = 6'd3;
  localparam logic [5:0] CMD_PRIO_C      = 6'd4;
  localparam logic [5:0] CMD_COMP_BEGIN  = 6'd0;
  localparam logic [5:0] CMD_COMP_END    = 6'd1;
  localparam logic [5:0] CMD_COMP_STEP   = 6'd2;
  localparam logic [5:0] CMD_RESERVE     = 6'd3;
  localparam logic [5:0] CMD_SWAP        = 6'd4;

  // event codes
  localparam logic [5:0] EV_NONE         = 6'd0;
  localparam logic [5:0] EV_CLK_TOGGLE   = 6'd1;
  localparam logic [5:0] EV_CLK_STOP     = 6'd2;
  localparam logic [5:0] EV_CLK_START    = 6'd3;
  localparam logic [5:0] EV_SCORE        = 6'd4;
  localparam logic [5:0] EV_YELLOW       = 6'd8;
  localparam logic [5:0] EV_RED          = 6'd12;
  localparam logic [5:0] EV_BLACK        = 6'd16;
  localparam logic [5:0] EV_PCARD_UNDO   = 6'd20;
  localparam logic [5:0] EV_PCARD_DO     = 6'd21;
  localparam logic [5:0] EV_BLACK_P      = 6'd22;
  localparam logic [5:0] EV_UNW_UNDO     = 6'd26;
  localparam logic [5:0] EV_UNW_BUZZ     = 6'd27;
  localparam logic [5:0] EV_NEXT_PERIOD  = 6'd28;
  localparam logic [5:0] EV_MATCH_RESET  = 6'd29;
  localparam logic [5:0] EV_PRIORITY     = 6'd30;
  localparam logic [5:0] EV_COMP_BEGIN   = 6'd31;
  localparam logic [5:0] EV_COMP_END     = 6'd32;
  localparam logic [5:0] EV_COMP_PREV    = 6'd33;
  localparam logic [5:0] EV_COMP_NEXT    = 6'd34;
  localparam logic [5:0] EV_RESERVE_L    = 6'd35;
  localparam logic [5:0] EV_RESERVE_R    = 6'd36;
  localparam logic [5:0] EV_SWAP         = 6'd37;
  localparam logic [5:0] EV_WEAPON       = 6'd38;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // group of four codes: undo left, do left, undo right, do right
  function automatic logic [5:0] sided(input logic [5:0] base, input logic [7:0] side,
                                       input logic undo);
    logic [5:0] off;
    off = undo ? 6'd0 : 6'd1;
    if (side == SIDE_LEFT) begin
      return base + off;
    end else if (side == SIDE_RIGHT) begin
      return base + 6'd2 + off;
    end
    return EV_NONE;
  endfunction

  function automatic logic [5:0] decode(input logic [31:0] frame);
    logic [7:0] cls;
    logic       undo;
    logic       cyc;
    logic [5:0] cmd;
    logic [7:0] side;
    logic [5:0] code;
    cls  = frame[31:24];
    undo = frame[23];
    cyc  = frame[22];
    cmd  = frame[21:16];
    side = frame[15:8];
    code = EV_NONE;
    unique case (cls)
      CLS_CLOCK: begin
        if (cmd == CMD_BASE) begin
          code = cyc ? EV_CLK_TOGGLE : (undo ? EV_CLK_STOP : EV_CLK_START);
        end
      end
      CLS_SCORE: begin
        if (cmd == CMD_BASE) begin
          code = sided(EV_SCORE, side, undo);
        end
      end
      CLS_CARD: begin
        unique case (cmd)
          CMD_YELLOW:    code = sided(EV_YELLOW, side, undo);
          CMD_RED:       code = sided(EV_RED, side, undo);
          CMD_BLACK:     code = sided(EV_BLACK, side, undo);
          CMD_PCARD:     code = undo ? EV_PCARD_UNDO : EV_PCARD_DO;
          CMD_BLACK_P:   code = sided(EV_BLACK_P, side, undo);
          CMD_UNWILLING: code = undo ? EV_UNW_UNDO : EV_UNW_BUZZ;
          default:       code = EV_NONE;
        endcase
      end
      CLS_MATCH: begin
        unique case (cmd)
          CMD_NEXT_PERIOD: code = undo ? EV_NONE : EV_NEXT_PERIOD;
          CMD_MATCH_RESET: code = EV_MATCH_RESET;
          CMD_PRIO_A, CMD_PRIO_B, CMD_PRIO_C: code = EV_PRIORITY;
          default:         code = EV_NONE;
        endcase
      end
      CLS_COMP: begin
        unique case (cmd)
          CMD_COMP_BEGIN: code = EV_COMP_BEGIN;
          CMD_COMP_END:   code = EV_COMP_END;
          CMD_COMP_STEP:  code = undo ? EV_COMP_PREV : EV_COMP_NEXT;
          CMD_RESERVE: begin
            if (side == SIDE_LEFT) begin
              code = EV_RESERVE_L;
            end else if (side == SIDE_RIGHT) begin
              code = EV_RESERVE_R;
            end
          end
          CMD_SWAP:       code = EV_SWAP;
          default:        code = EV_NONE;
        endcase
      end
      CLS_SETTINGS: begin
        if (cmd == CMD_BASE && cyc) begin
          code = EV_WEAPON;
        end
      end
      default: code = EV_NONE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/cfcd_collect.sv =====
// ----------------------------------------------------------------------------
// cfcd_collect: packet byte collector
// counts bytes, runs the crc over the head and keeps bytes 0 to 4
// ----------------------------------------------------------------------------
module cfcd_collect
  import cfcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] pkt_byte,
  input  logic       pkt_last,
  output pkt_info_t  info
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [39:0] head_r, head_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    head_nxt = head_r;
    if (take) begin
      if (pkt_last) begin
        cnt_nxt  = '0;
        crc_nxt  = '0;
        head_nxt = '0;
      end else begin
        if (cnt_r < CNT_LAST_IDX) begin
          crc_nxt  = crc8_step(crc_r, pkt_byte);
          head_nxt = {head_r[31:0], pkt_byte};
        end
        if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      crc_r  <= '0;
      head_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
      head_r <= head_nxt;
    end
  end

  // view of the packet as seen by the byte now offered
  assign info.len_ok = (cnt_r == CNT_LAST_IDX);
  assign info.crc_ok = (crc_r == pkt_byte);
  assign info.frame  = head_r[39:8];
  assign info.seq    = head_r[7:0];

endmodule

// ===== hdl/cfcd_judge.sv =====
// ----------------------------------------------------------------------------
// cfcd_judge: packet verdict and dedup record
// checks length, crc and repeats, then classifies and decodes the frame
// ----------------------------------------------------------------------------
module cfcd_judge
  import cfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        fire,
  input  pkt_info_t   info,
  input  logic [31:0] now_ms,
  output out_t        res
);

  logic [15:0] window_r;
  logic [31:0] last_frame_r;
  logic [7:0]  last_seq_r;
  logic [31:0] last_time_r;

  logic [31:0] elapsed;
  logic        is_dup;
  logic        rec_upd;
  logic [5:0]  code;

  assign elapsed = now_ms - last_time_r;
  assign is_dup  = (info.frame == last_frame_r) && (info.seq == last_seq_r) &&
                   (elapsed < {16'd0, window_r});
  assign code    = decode(info.frame);

  always_comb begin
    res     = '0;
    rec_upd = 1'b0;
    if (!info.len_ok) begin
      res.status = ST_BAD_LEN;
    end else begin
      res.frame_word = info.frame;
      res.seq_num    = info.seq;
      priority if (!info.crc_ok) begin
        res.status = ST_CRC_ERR;
      end else if (is_dup) begin
        res.status = ST_DUPLICATE;
      end else begin
        rec_upd = 1'b1;
        if (info.frame[31:24] == CLS_SYSTEM) begin
          res.status = ST_SYSTEM;
        end else if (code != EV_NONE) begin
          res.status     = ST_ACCEPTED;
          res.event_code = code;
        end else begin
          res.status = ST_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RESET;
      last_frame_r <= '0;
      last_seq_r   <= SEQ_RESET;
      last_time_r  <= '0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (fire && rec_upd) begin
        last_frame_r <= info.frame;
        last_seq_r   <= info.seq;
        last_time_r  <= now_ms;
      end
    end
  end

endmodule

// ===== hdl/command_frame_checker_decoder.sv =====
// ----------------------------------------------------------------------------
// command_frame_checker_decoder: checked command frame decoder
// collects 6-byte packets, checks length and crc-8, drops repeats, decodes
// ----------------------------------------------------------------------------
//
//  port group  | dir | payload | transfer when
//  ------------+-----+---------+-------------------------------
//  in_*        | in  | in_t    | in_valid high and in_stall low
//  out_*       | out | out_t   | out_valid high and out_stall low
//  cfg_*       | in  | 16 bit  | cfg_we high (dedup window, ms)
//
//  one byte per cycle sustained while in_stall is low; a last byte passes the
//  input register, then its result is held in the result register
//  in_stall rises only while a last byte waits on a full, stalled result
//  register; ordinary bytes never wait
//  synchronous active-low reset clears the byte counter, crc, dedup record
//  (sequence 0xff) and sets the window to 500 ms
//
module command_frame_checker_decoder
  import cfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // input register
  logic      s1_valid_r;
  in_t       s1_r;
  // result register
  logic      out_valid_r;
  out_t      out_r;

  logic      in_take;
  logic      s1_move;
  logic      fire;
  pkt_info_t info;
  out_t      res;

  // a plain byte always moves on; a last byte needs room in the result register
  assign s1_move  = s1_valid_r && (!s1_r.pkt_last || !out_valid_r || !out_stall);
  assign fire     = s1_move && s1_r.pkt_last;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_data;
    end
  end

  // byte counter, running crc and head bytes
  cfcd_collect u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (s1_move),
    .pkt_byte (s1_r.pkt_byte),
    .pkt_last (s1_r.pkt_last),
    .info     (info)
  );

  // verdict, dedup record and event decode
  cfcd_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .info      (info),
    .now_ms    (s1_r.now_ms),
    .res       (res)
  );

  // result register: loads on a last byte, empties when the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // an event code goes with an accepted frame and only with it
  a_code_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.status == ST_ACCEPTED) == (out_r.event_code != EV_NONE)))
    else $error("event code does not match status");

  // a bad-length packet carries no frame or sequence
  a_bad_len_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_BAD_LEN) |-> (out_r.frame_word == '0 &&
                                                       out_r.seq_num == '0))
    else $error("bad-length result carries payload");

  // back-pressure only ever comes from a waiting last byte
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_r.pkt_last && out_valid_r && out_stall))
    else $error("input stalled without a blocked last byte");

  // a last byte that is let through is loaded into the result register
  a_fire_loads : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("result lost after last byte");

endmodule
